@@ hdl/irdt_pkg.sv @@
package irdt_pkg;

  // Fixed field widths of the two channels.
  localparam int unsigned InValueW = 64;
  localparam int unsigned InFuncW  = 3;
  localparam int unsigned CharW    = 8;
  localparam int unsigned DigitW   = 4;

  // floor(w * log10(2)) is (w * Log2Num) >> 12 for the widths in use.
  localparam int unsigned Log2Num = 1233;
  localparam int unsigned Log2Den = 4096;

  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharLowA  = 8'h61;
  localparam logic [CharW-1:0] CharUpA   = 8'h41;

  typedef struct packed {
    logic [InValueW-1:0] value;
    logic [InFuncW-1:0]  func;
  } in_word_t;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic             last;
  } out_word_t;

  typedef enum logic [InFuncW-1:0] {
    FMT_RAW = 3'd0,
    FMT_BIN = 3'd1,
    FMT_OCT = 3'd2,
    FMT_HXL = 3'd3,
    FMT_HXU = 3'd4,
    FMT_DEC = 3'd5
  } fmt_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_CLEAR  = 2'd1,
    CELL_DABBLE = 2'd2,
    CELL_SHIFT  = 2'd3
  } cell_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DABBLE = 2'd1,
    ST_EMIT   = 2'd2
  } state_e;

  // Hex digit to ASCII, lower or upper case letters.
  function automatic logic [CharW-1:0] hex_char(input logic [DigitW-1:0] d,
                                                input logic upper);
    logic [CharW-1:0] ext;
    ext = {{(CharW-DigitW){1'b0}}, d};
    if (d < 4'd10) begin
      hex_char = CharZero + ext;
    end else if (upper) begin
      hex_char = CharUpA + ext - 8'd10;
    end else begin
      hex_char = CharLowA + ext - 8'd10;
    end
  endfunction

endpackage

@@ hdl/irdt_digit_cell.sv @@
module irdt_digit_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  irdt_pkg::cell_mode_e             mode_i,
  input  logic                             carry_i,
  input  logic [irdt_pkg::DigitW-1:0]      digit_i,
  output logic                             carry_o,
  output logic [irdt_pkg::DigitW-1:0]      digit_o
);
  import irdt_pkg::*;

  logic [DigitW-1:0] digit_q, digit_d;
  logic [DigitW-1:0] adj;

  // add-3 correction before each doubling
  assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
  assign carry_o = adj[DigitW-1];
  assign digit_o = digit_q;

  always_comb begin
    unique case (mode_i)
      CELL_HOLD:   digit_d = digit_q;
      CELL_CLEAR:  digit_d = '0;
      CELL_DABBLE: digit_d = {adj[DigitW-2:0], carry_i};
      CELL_SHIFT:  digit_d = digit_i;
      default:     digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

@@ hdl/integer_to_radix_digit_text.sv @@
// Timing: a raw or power-of-two value goes straight to emit; each character is
//   registered into the output word, and skipped leading zeros delay the first one.
//   Decimal first runs W dabble steps, then emits from the BCD cell row.
// Values: taken one at a time, only while idle; each digit slot waits for the receiver.
//   Digit slots: 1 raw, W / ceil(W/3) / ceil(W/4) for binary/octal/hex, NDIG decimal.
// Reset: rst_ni asynchronous, active low; clears FSM, counters and output valid.
module integer_to_radix_digit_text #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  irdt_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output irdt_pkg::out_word_t out_word_o
);
  import irdt_pkg::*;

  // Working register is padded so every radix's top digit lands at the MSB.
  localparam int unsigned PW    = VALUE_WIDTH + 3;
  localparam int unsigned NB    = VALUE_WIDTH;
  localparam int unsigned NO    = (VALUE_WIDTH + 2) / 3;
  localparam int unsigned NH    = (VALUE_WIDTH + 3) / 4;
  localparam int unsigned NDIG  = (VALUE_WIDTH * Log2Num) / Log2Den + 1;
  localparam int unsigned PAD_B = PW - NB;
  localparam int unsigned PAD_O = PW - 3 * NO;
  localparam int unsigned PAD_H = PW - 4 * NH;
  localparam int unsigned PAD_D = PW - VALUE_WIDTH;
  localparam int unsigned CW    = $clog2(VALUE_WIDTH + 1);

  state_e               state_q, state_d;
  fmt_e                 fmt_q, fmt_d, fmt_in;
  logic [PW-1:0]        vreg_q, vreg_d, val_ext;
  logic [CW-1:0]        rem_q, rem_d;
  logic [CW-1:0]        step_q, step_d;
  logic                 started_q, started_d;
  logic [CharW-1:0]     raw_q, raw_d;
  logic                 ovalid_q, ovalid_d;
  out_word_t            oword_q, oword_d;

  cell_mode_e           cell_mode;
  logic [NDIG-1:0]      carry_in, carry_out;
  logic [DigitW-1:0]    dig_in  [NDIG];
  logic [DigitW-1:0]    dig_out [NDIG];

  logic                 accept, can_load, emit_now;
  logic [DigitW-1:0]    top4, cur_digit;
  logic [CharW-1:0]     cur_char;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign can_load    = !ovalid_q || out_ready_i;
  assign out_valid_o = ovalid_q;
  assign out_word_o  = oword_q;
  assign val_ext     = PW'(in_word_i.value[VALUE_WIDTH-1:0]);

  // Codes past decimal are taken as decimal.
  always_comb begin
    unique case (in_word_i.func)
      FMT_RAW: fmt_in = FMT_RAW;
      FMT_BIN: fmt_in = FMT_BIN;
      FMT_OCT: fmt_in = FMT_OCT;
      FMT_HXL: fmt_in = FMT_HXL;
      FMT_HXU: fmt_in = FMT_HXU;
      default: fmt_in = FMT_DEC;
    endcase
  end

  // ---------------------------------------------------------------------------
  // BCD cell row: cell 0 is the ones digit. During dabble the value MSB enters
  // cell 0 and carries ripple upward; during emit digits move up one cell a
  // cycle while the output register can load, and the top cell is read out.
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < NDIG; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign carry_in[k] = vreg_q[PW-1];
      assign dig_in[k]   = '0;
    end else begin : g_rest
      assign carry_in[k] = carry_out[k-1];
      assign dig_in[k]   = dig_out[k-1];
    end
    irdt_digit_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .mode_i  (cell_mode),
      .carry_i (carry_in[k]),
      .digit_i (dig_in[k]),
      .carry_o (carry_out[k]),
      .digit_o (dig_out[k])
    );
  end

  // Current digit and its character.
  assign top4 = vreg_q[PW-1 -: DigitW];
  always_comb begin
    case (fmt_q)
      FMT_BIN: cur_digit = {3'b000, top4[3]};
      FMT_OCT: cur_digit = {1'b0, top4[3:1]};
      FMT_HXL, FMT_HXU: cur_digit = top4;
      default: cur_digit = dig_out[NDIG-1];
    endcase
  end

  always_comb begin
    case (fmt_q)
      FMT_RAW: cur_char = raw_q;
      FMT_HXU: cur_char = hex_char(cur_digit, 1'b1);
      default: cur_char = hex_char(cur_digit, 1'b0);
    endcase
  end

  // Leading zeros are skipped; the final digit always goes out.
  assign emit_now = started_q || (cur_digit != '0) || (rem_q == CW'(1))
                    || (fmt_q == FMT_RAW);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (fmt_in == FMT_DEC) ? ST_DABBLE : ST_EMIT;
        end
      end
      ST_DABBLE: begin
        if (step_q == CW'(1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (can_load && (rem_q == CW'(1))) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    vreg_d    = vreg_q;
    rem_d     = rem_q;
    step_d    = step_q;
    started_d = started_q;
    raw_d     = raw_q;
    fmt_d     = fmt_q;
    cell_mode = CELL_HOLD;
    ovalid_d  = ovalid_q && !out_ready_i;
    oword_d   = oword_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          fmt_d     = fmt_in;
          started_d = 1'b0;
          raw_d     = in_word_i.value[CharW-1:0];
          step_d    = CW'(VALUE_WIDTH);
          cell_mode = CELL_CLEAR;
          case (fmt_in)
            FMT_RAW: begin
              rem_d  = CW'(1);
              vreg_d = val_ext;
            end
            FMT_BIN: begin
              rem_d  = CW'(NB);
              vreg_d = val_ext << PAD_B;
            end
            FMT_OCT: begin
              rem_d  = CW'(NO);
              vreg_d = val_ext << PAD_O;
            end
            FMT_HXL, FMT_HXU: begin
              rem_d  = CW'(NH);
              vreg_d = val_ext << PAD_H;
            end
            default: begin
              rem_d  = CW'(NDIG);
              vreg_d = val_ext << PAD_D;
            end
          endcase
        end
      end
      ST_DABBLE: begin
        cell_mode = CELL_DABBLE;
        vreg_d    = vreg_q << 1;
        step_d    = step_q - CW'(1);
      end
      ST_EMIT: begin
        if (can_load) begin
          if (emit_now) begin
            ovalid_d          = 1'b1;
            oword_d.character = cur_char;
            oword_d.last      = (rem_q == CW'(1));
            started_d         = 1'b1;
          end
          rem_d = rem_q - CW'(1);
          case (fmt_q)
            FMT_BIN: vreg_d = vreg_q << 1;
            FMT_OCT: vreg_d = vreg_q << 3;
            FMT_HXL, FMT_HXU: vreg_d = vreg_q << 4;
            FMT_DEC: cell_mode = CELL_SHIFT;
            default: vreg_d = vreg_q;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fmt_q     <= FMT_RAW;
      rem_q     <= '0;
      step_q    <= '0;
      started_q <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      fmt_q     <= fmt_d;
      rem_q     <= rem_d;
      step_q    <= step_d;
      started_q <= started_d;
      ovalid_q  <= ovalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    vreg_q  <= vreg_d;
    raw_q   <= raw_d;
    oword_q <= oword_d;
  end

endmodule
